FILE: rtl/tblsc_pkg.sv
// Shared types, constants and register codes for the tick button/LED/scan controller.
package tblsc_pkg;

  localparam int SCAN_CHANNELS = 8;
  localparam int SCAN_CH_W     = (SCAN_CHANNELS > 1) ? $clog2(SCAN_CHANNELS) : 1;
  localparam int CH_EXT_W      = (SCAN_CH_W > 3) ? SCAN_CH_W : 3;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 18;

  localparam logic [15:0] LED_HOLDOFF_RESET  = 16'd18000;
  localparam logic [15:0] TEST_HOLDOFF_RESET = 16'd20000;
  localparam logic [16:0] BLINK_LIMIT_RESET  = 17'd55000;
  localparam logic [17:0] BATTERY_TMO_RESET  = 18'd144000;
  localparam logic [2:0]  PRESSES_RESET      = 3'd2;
  localparam logic [2:0]  TALLY_MAX          = 3'd7;
  localparam logic [31:0] OVERRUN_MAX        = 32'hFFFF_FFFF;
  localparam logic [SCAN_CH_W-1:0] SCAN_LAST = SCAN_CH_W'(SCAN_CHANNELS - 1);

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LED_HOLDOFF  = 3'd0,
    CFG_TEST_HOLDOFF = 3'd1,
    CFG_BLINK_LIMIT  = 3'd2,
    CFG_BATTERY_TMO  = 3'd3,
    CFG_PRESSES      = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [15:0] led_holdoff_ticks;
    logic [15:0] test_holdoff_ticks;
    logic [16:0] blink_limit;
    logic [17:0] battery_timeout_ticks;
    logic [2:0]  presses_to_toggle;
  } cfg_t;

  typedef struct packed {
    logic led_button_event;
    logic test_button_event;
    logic scan_enable;
    logic single_mode;
    logic system_ready;
    logic battery_check_start;
    logic sample_done;
  } tick_t;

  typedef struct packed {
    logic        green_led;
    logic        yellow_led;
    logic        red_led_off;
    logic        usb_mode;
    logic        led_irq_reenable;
    logic        test_irq_reenable;
    logic        convert_start;
    logic [2:0]  convert_channel;
    logic        scan_cycle_begin;
    logic [31:0] overrun_count;
  } result_t;

endpackage

FILE: rtl/tblsc_cfg_regs.sv
// Configuration register file written through the valid/ready write channel.
module tblsc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tblsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tblsc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output tblsc_pkg::cfg_t                  cfg
);
  import tblsc_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.led_holdoff_ticks     <= LED_HOLDOFF_RESET;
      cfg.test_holdoff_ticks    <= TEST_HOLDOFF_RESET;
      cfg.blink_limit           <= BLINK_LIMIT_RESET;
      cfg.battery_timeout_ticks <= BATTERY_TMO_RESET;
      cfg.presses_to_toggle     <= PRESSES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LED_HOLDOFF:  cfg.led_holdoff_ticks     <= cfg_data[15:0];
        CFG_TEST_HOLDOFF: cfg.test_holdoff_ticks    <= cfg_data[15:0];
        CFG_BLINK_LIMIT:  cfg.blink_limit           <= cfg_data[16:0];
        CFG_BATTERY_TMO:  cfg.battery_timeout_ticks <= cfg_data[17:0];
        CFG_PRESSES:      cfg.presses_to_toggle     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: rtl/tblsc_tick_core.sv
// Controller state registers and the single-pass update for one tick.
module tblsc_tick_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  tblsc_pkg::tick_t   tick,
  input  tblsc_pkg::cfg_t    cfg,
  output tblsc_pkg::result_t result
);
  import tblsc_pkg::*;

  logic                 led_holdoff_active, led_holdoff_active_next;
  logic [15:0]          led_holdoff_count, led_holdoff_count_next;
  logic                 led_press_pending, led_press_pending_next;
  logic                 test_holdoff_active, test_holdoff_active_next;
  logic [15:0]          test_holdoff_count, test_holdoff_count_next;
  logic [2:0]           press_tally, press_tally_next;
  logic [16:0]          blink_count, blink_count_next;
  logic                 blink_enabled, blink_enabled_next;
  logic                 green_state, green_state_next;
  logic                 yellow_state, yellow_state_next;
  logic                 battery_active, battery_active_next;
  logic [17:0]          battery_count, battery_count_next;
  logic                 mode_usb, mode_usb_next;
  logic [SCAN_CH_W-1:0] scan_channel, scan_channel_next;
  logic                 sample_taken, sample_taken_next;
  logic [31:0]          overrun_total, overrun_total_next;
  logic [CH_EXT_W-1:0]  ch_ext;

  always_comb begin
    led_holdoff_active_next  = led_holdoff_active  | tick.led_button_event;
    led_press_pending_next   = led_press_pending   | tick.led_button_event;
    test_holdoff_active_next = test_holdoff_active | tick.test_button_event;
    battery_active_next      = battery_active      | tick.battery_check_start;
    sample_taken_next        = sample_taken        | tick.sample_done;
    led_holdoff_count_next   = led_holdoff_count;
    test_holdoff_count_next  = test_holdoff_count;
    press_tally_next         = press_tally;
    blink_count_next         = blink_count;
    blink_enabled_next       = blink_enabled;
    green_state_next         = green_state;
    yellow_state_next        = yellow_state;
    battery_count_next       = battery_count;
    mode_usb_next            = mode_usb;
    scan_channel_next        = scan_channel;
    overrun_total_next       = overrun_total;
    result                   = '0;

    if (led_holdoff_active_next) led_holdoff_count_next = led_holdoff_count + 16'd1;
    if (led_holdoff_count_next >= cfg.led_holdoff_ticks) begin
      result.led_irq_reenable = 1'b1;
      led_holdoff_count_next  = '0;
      led_holdoff_active_next = 1'b0;
    end

    if (test_holdoff_active_next) test_holdoff_count_next = test_holdoff_count + 16'd1;
    if (test_holdoff_count_next >= cfg.test_holdoff_ticks) begin
      result.test_irq_reenable = 1'b1;
      test_holdoff_count_next  = '0;
      test_holdoff_active_next = 1'b0;
    end

    if (led_press_pending_next && !led_holdoff_active_next) begin
      if (press_tally != TALLY_MAX) press_tally_next = press_tally + 3'd1;
      led_press_pending_next = 1'b0;
    end

    if (tick.system_ready && blink_enabled) begin
      if (blink_count >= cfg.blink_limit) begin
        green_state_next = ~green_state;
        blink_count_next = '0;
      end else begin
        blink_count_next = blink_count + 17'd1;
      end
    end

    if (battery_active_next) battery_count_next = battery_count + 18'd1;
    if (battery_count_next >= cfg.battery_timeout_ticks) begin
      result.red_led_off  = 1'b1;
      battery_active_next = 1'b0;
      press_tally_next    = '0;
      battery_count_next  = '0;
    end

    if (press_tally_next >= cfg.presses_to_toggle) begin
      mode_usb_next      = ~mode_usb;
      press_tally_next   = '0;
      result.red_led_off = 1'b1;
      yellow_state_next  = ~mode_usb;
      green_state_next   = ~mode_usb;
      blink_enabled_next = mode_usb;
    end

    if (tick.single_mode && sample_taken_next) begin
      result.convert_start = 1'b1;
      sample_taken_next    = 1'b0;
    end

    ch_ext = '0;
    if (tick.scan_enable) begin
      if (!sample_taken_next) begin
        if (overrun_total != OVERRUN_MAX) overrun_total_next = overrun_total + 32'd1;
      end else begin
        scan_channel_next       = (scan_channel == SCAN_LAST) ? '0 : scan_channel + 1'b1;
        result.convert_start    = 1'b1;
        ch_ext                  = CH_EXT_W'(scan_channel_next);
        result.scan_cycle_begin = (scan_channel_next == '0);
        sample_taken_next       = 1'b0;
      end
    end

    result.convert_channel = ch_ext[2:0];
    result.green_led       = green_state_next;
    result.yellow_led      = yellow_state_next;
    result.usb_mode        = mode_usb_next;
    result.overrun_count   = overrun_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_holdoff_active  <= 1'b0;
      led_holdoff_count   <= '0;
      led_press_pending   <= 1'b0;
      test_holdoff_active <= 1'b0;
      test_holdoff_count  <= '0;
      press_tally         <= '0;
      blink_count         <= '0;
      blink_enabled       <= 1'b1;
      green_state         <= 1'b0;
      yellow_state        <= 1'b0;
      battery_active      <= 1'b0;
      battery_count       <= '0;
      mode_usb            <= 1'b0;
      scan_channel        <= SCAN_LAST;
      sample_taken        <= 1'b1;
      overrun_total       <= '0;
    end else if (advance) begin
      led_holdoff_active  <= led_holdoff_active_next;
      led_holdoff_count   <= led_holdoff_count_next;
      led_press_pending   <= led_press_pending_next;
      test_holdoff_active <= test_holdoff_active_next;
      test_holdoff_count  <= test_holdoff_count_next;
      press_tally         <= press_tally_next;
      blink_count         <= blink_count_next;
      blink_enabled       <= blink_enabled_next;
      green_state         <= green_state_next;
      yellow_state        <= yellow_state_next;
      battery_active      <= battery_active_next;
      battery_count       <= battery_count_next;
      mode_usb            <= mode_usb_next;
      scan_channel        <= scan_channel_next;
      sample_taken        <= sample_taken_next;
      overrun_total       <= overrun_total_next;
    end
  end

endmodule

FILE: rtl/tick_button_led_scan_controller.sv
// Tick-driven button, LED and converter-scan controller, top level.
//
// One timer tick is taken per clock cycle while in_stall is low. A tick is
// captured in an input register, updated against the controller state in a
// single pass of counter/compare logic, and the result lands in an output
// register. The output register holds its result while the consumer stalls;
// the input register keeps taking ticks until both stages are full.
// Configuration writes complete in the cycle they are presented and apply to
// ticks processed afterwards.
module tick_button_led_scan_controller (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              led_button_event,
  input  logic                              test_button_event,
  input  logic                              scan_enable,
  input  logic                              single_mode,
  input  logic                              system_ready,
  input  logic                              battery_check_start,
  input  logic                              sample_done,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              green_led,
  output logic                              yellow_led,
  output logic                              red_led_off,
  output logic                              usb_mode,
  output logic                              led_irq_reenable,
  output logic                              test_irq_reenable,
  output logic                              convert_start,
  output logic [2:0]                        convert_channel,
  output logic                              scan_cycle_begin,
  output logic [31:0]                       overrun_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tblsc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tblsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tblsc_pkg::*;

  cfg_t    cfg;
  tick_t   tick_reg;
  logic    tick_valid;
  logic    advance;
  result_t result;
  result_t result_reg;

  assign advance  = tick_valid && (!out_valid || !out_stall);
  assign in_stall = tick_valid && !advance;

  tblsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tblsc_tick_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .tick    (tick_reg),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_valid <= 1'b0;
    end else if (!in_stall) begin
      tick_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      tick_reg.led_button_event    <= led_button_event;
      tick_reg.test_button_event   <= test_button_event;
      tick_reg.scan_enable         <= scan_enable;
      tick_reg.single_mode         <= single_mode;
      tick_reg.system_ready        <= system_ready;
      tick_reg.battery_check_start <= battery_check_start;
      tick_reg.sample_done         <= sample_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_reg <= result;
    end
  end

  assign green_led         = result_reg.green_led;
  assign yellow_led        = result_reg.yellow_led;
  assign red_led_off       = result_reg.red_led_off;
  assign usb_mode          = result_reg.usb_mode;
  assign led_irq_reenable  = result_reg.led_irq_reenable;
  assign test_irq_reenable = result_reg.test_irq_reenable;
  assign convert_start     = result_reg.convert_start;
  assign convert_channel   = result_reg.convert_channel;
  assign scan_cycle_begin  = result_reg.scan_cycle_begin;
  assign overrun_count     = result_reg.overrun_count;

endmodule
